// ===== rtl/ldst_pkg.sv =====
// Shared types and constants of the load/store unit.
`timescale 1ns / 1ps
package ldst_pkg;

    // Register file slots: B,C,D,E,H,L,(unused),A
    localparam logic [2:0] REG_B = 3'd0;
    localparam logic [2:0] REG_C = 3'd1;
    localparam logic [2:0] REG_D = 3'd2;
    localparam logic [2:0] REG_E = 3'd3;
    localparam logic [2:0] REG_H = 3'd4;
    localparam logic [2:0] REG_L = 3'd5;
    localparam logic [2:0] REG_M = 3'd6;
    localparam logic [2:0] REG_A = 3'd7;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_AWAIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_WRITE = 2'd2;

    // Opcodes decoded by name
    localparam logic [7:0] OPC_HALT    = 8'h76;
    localparam logic [7:0] OPC_LD_BC_A = 8'h02;
    localparam logic [7:0] OPC_LD_DE_A = 8'h12;
    localparam logic [7:0] OPC_LD_A_BC = 8'h0A;
    localparam logic [7:0] OPC_LD_A_DE = 8'h1A;
    localparam logic [7:0] OPC_LD_A_NN = 8'hFA;
    localparam logic [7:0] OPC_LD_NN_A = 8'hEA;
    localparam logic [7:0] OPC_LD_A_HC = 8'hF2;
    localparam logic [7:0] OPC_LD_HC_A = 8'hE2;
    localparam logic [7:0] OPC_LD_A_HN = 8'hF0;
    localparam logic [7:0] OPC_LD_HN_A = 8'hE0;
    localparam logic [7:0] OPC_LDI_A   = 8'h2A;
    localparam logic [7:0] OPC_LDD_A   = 8'h3A;
    localparam logic [7:0] OPC_LDI_M   = 8'h22;
    localparam logic [7:0] OPC_LDD_M   = 8'h32;
    localparam logic [7:0] OPC_LD_BC   = 8'h01;
    localparam logic [7:0] OPC_LD_DE   = 8'h11;
    localparam logic [7:0] OPC_LD_HL   = 8'h21;
    localparam logic [7:0] OPC_LD_SP   = 8'h31;
    localparam logic [7:0] OPC_SP_HL   = 8'hF9;
    localparam logic [7:0] OPC_HL_SPE  = 8'hF8;
    localparam logic [7:0] OPC_ST_SP   = 8'h08;

    // Command queue between decode and execute
    localparam int CQ_AW    = 2;
    localparam int CQ_DEPTH = 1 << CQ_AW;
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    // Result queue at the output
    localparam int OQ_AW    = 2;
    localparam int OQ_DEPTH = 1 << OQ_AW;
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_BAD,    // unsupported opcode
        OP_RET,    // read data coming back
        OP_MOVE,   // r <- r'
        OP_LDN,    // r <- n
        OP_STORE,  // (addr) <- r or n
        OP_LOAD,   // r <- (addr), read request
        OP_LD16,   // rr <- nn
        OP_SPHL,   // SP <- HL
        OP_HLSPE,  // HL <- SP + e
        OP_STSP    // (nn) <- SP, two writes
    } t_op;

    typedef enum logic [2:0] {
        ADDR_HL,
        ADDR_BC,
        ADDR_DE,
        ADDR_IMM,
        ADDR_HIC,
        ADDR_HIN
    } t_addr;

    typedef enum logic [1:0] {
        HL_KEEP,
        HL_INC,
        HL_DEC
    } t_hladj;

    typedef enum logic [1:0] {
        PAIR_BC,
        PAIR_DE,
        PAIR_HL,
        PAIR_SP
    } t_pair;

    typedef struct packed {
        t_op         op;
        t_addr       asel;
        t_hladj      hladj;
        t_pair       pair;
        logic [2:0]  dst;
        logic [2:0]  src;
        logic        use_imm;
        logic [1:0]  step;
        logic [2:0]  cycles;
        logic [15:0] imm;
        logic [7:0]  rdata;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [2:0]  cycles;
        logic        last;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [3:0]  flags;
    } t_res;

endpackage

// ===== rtl/cpu8_load_store_unit.sv =====
// Top level of the 8-bit CPU load/store unit.
`timescale 1ns / 1ps
// Executes the load group of an LR35902-style CPU (LD r,r'; LD r,n; indirect
// loads and stores through BC, DE, HL; LD (nn); high-page forms through C or n;
// HL post-increment/decrement; LD rr,nn; LD SP,HL; LD HL,SP+e; LD (nn),SP).
// Both sides look like queues: an item is taken when push is high and
// full low, and a result leaves when pop is high and empty low. A new
// instruction item (i_operation 0) yields one result, LD (nn),SP yields two
// (low byte to nn, then high byte to nn+1, o_last marks the second). A load
// yields a read request with status "awaiting"; the requester returns the
// byte as an item with i_operation 1, which writes the target register and
// yields the finishing result with the machine-cycle count. A new instruction
// while a read is outstanding drops that read. The decoder writes into a
// four-entry command queue; the execute stage takes one command per clock
// whenever its four-entry result queue has room for two results, so the unit
// sustains one item per cycle while results are popped and no item yields
// two. The first result of an item passes the command queue, then enters
// the result queue to be popped; execution stalls only while more than two
// results are waiting. Register state and HL/PC updates happen in the execute
// stage; every result carries PC, A, HL, SP and flags as they stand after it.
module cpu8_load_store_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        push,
    output logic        full,
    input  logic        i_operation,
    input  logic [7:0]  i_opcode,
    input  logic [15:0] i_immediate,
    input  logic [7:0]  i_read_data,

    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [1:0]  o_access_kind,
    output logic [15:0] o_access_address,
    output logic [7:0]  o_write_data,
    output logic [2:0]  o_machine_cycles,
    output logic        o_last,
    output logic [15:0] o_program_counter_out,
    output logic [7:0]  o_accumulator_out,
    output logic [15:0] o_hl_out,
    output logic [15:0] o_stack_pointer_out,
    output logic [3:0]  o_flags_out
);

    ldst_pkg::t_cmd dec_cmd;
    ldst_pkg::t_cmd q_cmd;
    ldst_pkg::t_res res;
    logic           q_empty;
    logic           q_pop;

    // Front: classify the incoming item
    ldst_front u_front (
        .i_operation (i_operation),
        .i_opcode    (i_opcode),
        .i_immediate (i_immediate),
        .i_read_data (i_read_data),
        .o_cmd       (dec_cmd)
    );

    // Decouples acceptance from execution stalls
    ldst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (dec_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    // Back: execute and queue results
    ldst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!q_empty),
        .o_cmd_pop   (q_pop),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_status              = res.status;
    assign o_access_kind         = res.kind;
    assign o_access_address      = res.addr;
    assign o_write_data          = res.wdata;
    assign o_machine_cycles      = res.cycles;
    assign o_last                = res.last;
    assign o_program_counter_out = res.pc;
    assign o_accumulator_out     = res.acc;
    assign o_hl_out              = res.hl;
    assign o_stack_pointer_out   = res.sp;
    assign o_flags_out           = res.flags;

endmodule

// ===== rtl/ldst_front.sv =====
// Decoder: classifies each item into an execute command.
`timescale 1ns / 1ps
module ldst_front (
    input  logic            i_operation,
    input  logic [7:0]      i_opcode,
    input  logic [15:0]     i_immediate,
    input  logic [7:0]      i_read_data,
    output ldst_pkg::t_cmd  o_cmd
);

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = ldst_pkg::OP_BAD;
        o_cmd.asel    = ldst_pkg::ADDR_HL;
        o_cmd.hladj   = ldst_pkg::HL_KEEP;
        o_cmd.pair    = ldst_pkg::PAIR_BC;
        o_cmd.dst     = ldst_pkg::REG_A;
        o_cmd.src     = ldst_pkg::REG_A;
        o_cmd.imm     = i_immediate;
        o_cmd.rdata   = i_read_data;
        o_cmd.cycles  = 3'd2;

        if (i_operation) begin
            o_cmd.op = ldst_pkg::OP_RET;
        end else if (i_opcode[7:6] == 2'b01 && i_opcode != ldst_pkg::OPC_HALT) begin
            o_cmd.dst  = i_opcode[5:3];
            o_cmd.src  = i_opcode[2:0];
            o_cmd.step = 2'd1;
            if (i_opcode[2:0] == ldst_pkg::REG_M) begin
                o_cmd.op = ldst_pkg::OP_LOAD;
            end else if (i_opcode[5:3] == ldst_pkg::REG_M) begin
                o_cmd.op = ldst_pkg::OP_STORE;
            end else begin
                o_cmd.op     = ldst_pkg::OP_MOVE;
                o_cmd.cycles = 3'd1;
            end
        end else if (i_opcode[7:6] == 2'b00 && i_opcode[2:0] == 3'b110) begin
            o_cmd.dst  = i_opcode[5:3];
            o_cmd.step = 2'd2;
            if (i_opcode[5:3] == ldst_pkg::REG_M) begin
                o_cmd.op      = ldst_pkg::OP_STORE;
                o_cmd.use_imm = 1'b1;
                o_cmd.cycles  = 3'd3;
            end else begin
                o_cmd.op = ldst_pkg::OP_LDN;
            end
        end else begin
            case (i_opcode)
                ldst_pkg::OPC_LD_A_BC: begin
                    o_cmd.op = ldst_pkg::OP_LOAD; o_cmd.asel = ldst_pkg::ADDR_BC;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LD_A_DE: begin
                    o_cmd.op = ldst_pkg::OP_LOAD; o_cmd.asel = ldst_pkg::ADDR_DE;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LD_BC_A: begin
                    o_cmd.op = ldst_pkg::OP_STORE; o_cmd.asel = ldst_pkg::ADDR_BC;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LD_DE_A: begin
                    o_cmd.op = ldst_pkg::OP_STORE; o_cmd.asel = ldst_pkg::ADDR_DE;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LD_A_NN: begin
                    o_cmd.op = ldst_pkg::OP_LOAD; o_cmd.asel = ldst_pkg::ADDR_IMM;
                    o_cmd.step = 2'd3; o_cmd.cycles = 3'd4;
                end
                ldst_pkg::OPC_LD_NN_A: begin
                    o_cmd.op = ldst_pkg::OP_STORE; o_cmd.asel = ldst_pkg::ADDR_IMM;
                    o_cmd.step = 2'd3; o_cmd.cycles = 3'd4;
                end
                ldst_pkg::OPC_LD_A_HC: begin
                    o_cmd.op = ldst_pkg::OP_LOAD; o_cmd.asel = ldst_pkg::ADDR_HIC;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LD_HC_A: begin
                    o_cmd.op = ldst_pkg::OP_STORE; o_cmd.asel = ldst_pkg::ADDR_HIC;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LD_A_HN: begin
                    o_cmd.op = ldst_pkg::OP_LOAD; o_cmd.asel = ldst_pkg::ADDR_HIN;
                    o_cmd.step = 2'd2; o_cmd.cycles = 3'd3;
                end
                ldst_pkg::OPC_LD_HN_A: begin
                    o_cmd.op = ldst_pkg::OP_STORE; o_cmd.asel = ldst_pkg::ADDR_HIN;
                    o_cmd.step = 2'd2; o_cmd.cycles = 3'd3;
                end
                ldst_pkg::OPC_LDI_A: begin
                    o_cmd.op = ldst_pkg::OP_LOAD; o_cmd.hladj = ldst_pkg::HL_INC;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LDD_A: begin
                    o_cmd.op = ldst_pkg::OP_LOAD; o_cmd.hladj = ldst_pkg::HL_DEC;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LDI_M: begin
                    o_cmd.op = ldst_pkg::OP_STORE; o_cmd.hladj = ldst_pkg::HL_INC;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LDD_M: begin
                    o_cmd.op = ldst_pkg::OP_STORE; o_cmd.hladj = ldst_pkg::HL_DEC;
                    o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_LD_BC: begin
                    o_cmd.op = ldst_pkg::OP_LD16; o_cmd.pair = ldst_pkg::PAIR_BC;
                    o_cmd.step = 2'd3; o_cmd.cycles = 3'd3;
                end
                ldst_pkg::OPC_LD_DE: begin
                    o_cmd.op = ldst_pkg::OP_LD16; o_cmd.pair = ldst_pkg::PAIR_DE;
                    o_cmd.step = 2'd3; o_cmd.cycles = 3'd3;
                end
                ldst_pkg::OPC_LD_HL: begin
                    o_cmd.op = ldst_pkg::OP_LD16; o_cmd.pair = ldst_pkg::PAIR_HL;
                    o_cmd.step = 2'd3; o_cmd.cycles = 3'd3;
                end
                ldst_pkg::OPC_LD_SP: begin
                    o_cmd.op = ldst_pkg::OP_LD16; o_cmd.pair = ldst_pkg::PAIR_SP;
                    o_cmd.step = 2'd3; o_cmd.cycles = 3'd3;
                end
                ldst_pkg::OPC_SP_HL: begin
                    o_cmd.op = ldst_pkg::OP_SPHL; o_cmd.step = 2'd1;
                end
                ldst_pkg::OPC_HL_SPE: begin
                    o_cmd.op = ldst_pkg::OP_HLSPE; o_cmd.step = 2'd2; o_cmd.cycles = 3'd3;
                end
                ldst_pkg::OPC_ST_SP: begin
                    o_cmd.op = ldst_pkg::OP_STSP; o_cmd.step = 2'd3; o_cmd.cycles = 3'd5;
                end
                default: begin
                    o_cmd.op = ldst_pkg::OP_BAD;
                end
            endcase
        end
    end

endmodule

// ===== rtl/ldst_queue.sv =====
// Short command queue between decode and execute.
`timescale 1ns / 1ps
module ldst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ldst_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output ldst_pkg::t_cmd  o_cmd,
    output logic            o_empty
);

    ldst_pkg::t_cmd                  r_mem [ldst_pkg::CQ_DEPTH];
    logic [ldst_pkg::CQ_AW-1:0]      r_wp;
    logic [ldst_pkg::CQ_AW-1:0]      r_rp;
    logic [ldst_pkg::CQ_CW-1:0]      r_cnt;
    logic                            wr_en;
    logic                            rd_en;

    assign o_full  = (r_cnt == ldst_pkg::CQ_CW'(ldst_pkg::CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + ldst_pkg::CQ_CW'(wr_en) - ldst_pkg::CQ_CW'(rd_en);
        end
    end

endmodule

// ===== rtl/ldst_back.sv =====
// Execute stage: register state, access generation and result queue.
`timescale 1ns / 1ps
module ldst_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ldst_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    output ldst_pkg::t_res  o_res,
    output logic            o_empty,
    input  logic            i_pop
);

    localparam logic [ldst_pkg::OQ_CW-1:0] OQ_ROOM = ldst_pkg::OQ_CW'(ldst_pkg::OQ_DEPTH - 2);

    logic [7:0]  r_regs [8];
    logic [15:0] r_sp;
    logic [15:0] r_pc;
    logic [3:0]  r_flags;
    logic        r_await;
    logic [2:0]  r_tgt;
    logic [2:0]  r_pcyc;

    logic [7:0]  n_regs [8];
    logic [15:0] n_sp;
    logic [15:0] n_pc;
    logic [3:0]  n_flags;
    logic        n_await;
    logic [2:0]  n_tgt;
    logic [2:0]  n_pcyc;

    ldst_pkg::t_res                r_out [ldst_pkg::OQ_DEPTH];
    logic [ldst_pkg::OQ_AW-1:0]    r_wp;
    logic [ldst_pkg::OQ_AW-1:0]    r_rp;
    logic [ldst_pkg::OQ_CW-1:0]    r_cnt;

    ldst_pkg::t_res res0;
    ldst_pkg::t_res res1;
    logic           two;
    logic           take;
    logic           out_pop;
    logic [15:0]    hl;
    logic [15:0]    hl_new;
    logic [15:0]    base_addr;
    logic [7:0]     src_val;
    logic [4:0]     lo_nib;
    logic [8:0]     lo_byte;

    assign take      = i_cmd_valid && (r_cnt <= OQ_ROOM);
    assign o_cmd_pop = take;
    assign out_pop   = i_pop && !o_empty;
    assign o_empty   = (r_cnt == '0);
    assign o_res     = r_out[r_rp];

    assign hl      = {r_regs[ldst_pkg::REG_H], r_regs[ldst_pkg::REG_L]};
    assign src_val = r_regs[i_cmd.src];
    assign lo_nib  = {1'b0, r_sp[3:0]} + {1'b0, i_cmd.imm[3:0]};
    assign lo_byte = {1'b0, r_sp[7:0]} + {1'b0, i_cmd.imm[7:0]};

    always_comb begin
        case (i_cmd.asel)
            ldst_pkg::ADDR_HL:  base_addr = hl;
            ldst_pkg::ADDR_BC:  base_addr = {r_regs[ldst_pkg::REG_B], r_regs[ldst_pkg::REG_C]};
            ldst_pkg::ADDR_DE:  base_addr = {r_regs[ldst_pkg::REG_D], r_regs[ldst_pkg::REG_E]};
            ldst_pkg::ADDR_IMM: base_addr = i_cmd.imm;
            ldst_pkg::ADDR_HIC: base_addr = ldst_pkg::HIGH_PAGE | {8'h00, r_regs[ldst_pkg::REG_C]};
            ldst_pkg::ADDR_HIN: base_addr = ldst_pkg::HIGH_PAGE | {8'h00, i_cmd.imm[7:0]};
            default:            base_addr = hl;
        endcase
    end

    always_comb begin
        case (i_cmd.hladj)
            ldst_pkg::HL_INC: hl_new = hl + 16'd1;
            ldst_pkg::HL_DEC: hl_new = hl - 16'd1;
            default:          hl_new = hl;
        endcase
    end

    always_comb begin
        n_regs  = r_regs;
        n_sp    = r_sp;
        n_pc    = r_pc;
        n_flags = r_flags;
        n_await = r_await;
        n_tgt   = r_tgt;
        n_pcyc  = r_pcyc;
        two     = 1'b0;
        res0    = '0;
        res0.status = ldst_pkg::ST_DONE;
        res0.kind   = ldst_pkg::ACC_NONE;
        res0.cycles = i_cmd.cycles;
        res0.last   = 1'b1;

        if (i_cmd.op == ldst_pkg::OP_RET) begin
            if (!r_await) begin
                res0.status = ldst_pkg::ST_BAD;
                res0.cycles = 3'd0;
            end else begin
                n_regs[r_tgt] = i_cmd.rdata;
                n_await       = 1'b0;
                res0.cycles   = r_pcyc;
            end
        end else begin
            // any new instruction drops a pending read
            n_await = 1'b0;
            n_pc    = r_pc + {14'd0, i_cmd.step};
            if (i_cmd.hladj != ldst_pkg::HL_KEEP) begin
                n_regs[ldst_pkg::REG_H] = hl_new[15:8];
                n_regs[ldst_pkg::REG_L] = hl_new[7:0];
            end
            case (i_cmd.op)
                ldst_pkg::OP_MOVE: n_regs[i_cmd.dst] = src_val;
                ldst_pkg::OP_LDN:  n_regs[i_cmd.dst] = i_cmd.imm[7:0];
                ldst_pkg::OP_STORE: begin
                    res0.kind  = ldst_pkg::ACC_WRITE;
                    res0.addr  = base_addr;
                    res0.wdata = i_cmd.use_imm ? i_cmd.imm[7:0] : src_val;
                end
                ldst_pkg::OP_LOAD: begin
                    res0.kind   = ldst_pkg::ACC_READ;
                    res0.addr   = base_addr;
                    res0.status = ldst_pkg::ST_AWAIT;
                    res0.cycles = 3'd0;
                    n_await     = 1'b1;
                    n_tgt       = i_cmd.dst;
                    n_pcyc      = i_cmd.cycles;
                end
                ldst_pkg::OP_LD16: begin
                    case (i_cmd.pair)
                        ldst_pkg::PAIR_BC: begin
                            n_regs[ldst_pkg::REG_B] = i_cmd.imm[15:8];
                            n_regs[ldst_pkg::REG_C] = i_cmd.imm[7:0];
                        end
                        ldst_pkg::PAIR_DE: begin
                            n_regs[ldst_pkg::REG_D] = i_cmd.imm[15:8];
                            n_regs[ldst_pkg::REG_E] = i_cmd.imm[7:0];
                        end
                        ldst_pkg::PAIR_HL: begin
                            n_regs[ldst_pkg::REG_H] = i_cmd.imm[15:8];
                            n_regs[ldst_pkg::REG_L] = i_cmd.imm[7:0];
                        end
                        default: n_sp = i_cmd.imm;
                    endcase
                end
                ldst_pkg::OP_SPHL: n_sp = hl;
                ldst_pkg::OP_HLSPE: begin
                    {n_regs[ldst_pkg::REG_H], n_regs[ldst_pkg::REG_L]} =
                        r_sp + {{8{i_cmd.imm[7]}}, i_cmd.imm[7:0]};
                    n_flags = {2'b00, lo_nib[4], lo_byte[8]};
                end
                ldst_pkg::OP_STSP: begin
                    res0.kind   = ldst_pkg::ACC_WRITE;
                    res0.addr   = i_cmd.imm;
                    res0.wdata  = r_sp[7:0];
                    res0.cycles = 3'd0;
                    res0.last   = 1'b0;
                    two         = 1'b1;
                end
                default: begin
                    // unsupported: only the pending read is dropped
                    res0.status = ldst_pkg::ST_BAD;
                    res0.cycles = 3'd0;
                    n_pc        = r_pc;
                end
            endcase
        end

        res0.pc    = n_pc;
        res0.acc   = n_regs[ldst_pkg::REG_A];
        res0.hl    = {n_regs[ldst_pkg::REG_H], n_regs[ldst_pkg::REG_L]};
        res0.sp    = n_sp;
        res0.flags = n_flags;

        res1        = res0;
        res1.addr   = i_cmd.imm + 16'd1;
        res1.wdata  = r_sp[15:8];
        res1.cycles = i_cmd.cycles;
        res1.last   = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out[r_wp] <= res0;
            if (two) begin
                r_out[r_wp + 1'b1] <= res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= '0;
            end
            r_sp    <= '0;
            r_pc    <= '0;
            r_flags <= '0;
            r_await <= 1'b0;
            r_tgt   <= '0;
            r_pcyc  <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            if (take) begin
                r_regs  <= n_regs;
                r_sp    <= n_sp;
                r_pc    <= n_pc;
                r_flags <= n_flags;
                r_await <= n_await;
                r_tgt   <= n_tgt;
                r_pcyc  <= n_pcyc;
                r_wp    <= r_wp + (two ? ldst_pkg::OQ_AW'(2) : ldst_pkg::OQ_AW'(1));
            end
            if (out_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt
                     + (take ? (two ? ldst_pkg::OQ_CW'(2) : ldst_pkg::OQ_CW'(1))
                             : ldst_pkg::OQ_CW'(0))
                     - ldst_pkg::OQ_CW'(out_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ldst_pkg::OQ_CW'(ldst_pkg::OQ_DEPTH))
        else $error("result queue overflow");

    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (r_cnt <= OQ_ROOM))
        else $error("command taken without room for two results");

    a_load_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.op == ldst_pkg::OP_LOAD) |=> r_await)
        else $error("read request issued without pending state");

    a_slot_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs[ldst_pkg::REG_M] == 8'h00)
        else $error("unused register slot written");

endmodule
